// ===== src/vcp_pkg.sv =====
// ----------------------------------------------------------------------------
// vcp_pkg
// Types and constants shared by the control-packet header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vcp_pkg;

	// Parse phase of the packet walker
	typedef enum logic [2:0] {
		PH_OP   = 3'd0,
		PH_SID  = 3'd1,
		PH_CNT  = 3'd2,
		PH_ACK  = 3'd3,
		PH_ECHO = 3'd4,
		PH_PID  = 3'd5,
		PH_PAY  = 3'd6,
		PH_DROP = 3'd7
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_ACK     = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_SESSION   = 2'd1;
	localparam logic [1:0] ERR_ACK_COUNT = 2'd2;
	localparam logic [1:0] ERR_ACK_LIST  = 2'd3;

	// Configuration register indexes
	localparam logic [7:0] REG_MAX_ACK_COUNT   = 8'd0;
	localparam logic [7:0] REG_ACK_ONLY_OPCODE = 8'd1;

	// Fixed packet layout
	localparam logic [3:0] WORD_BYTES = 4'd4;

	// Result queue sizing: one byte can cause up to four results
	localparam int MAX_RESULTS = 4;
	localparam int QUEUE_DEPTH = 8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  opcode;
		logic [2:0]  key_id;
		logic [63:0] peer_session;
		logic [7:0]  ack_total;
		logic [31:0] value;
		logic        pid_valid;
		logic [1:0]  error_code;
		logic        packet_end;
	} result_t;

	// Fill in the per-result fields on top of the packet-wide ones
	function automatic result_t make_result(
		input result_t     base,
		input logic [1:0]  kind,
		input logic [31:0] value,
		input logic        has_pid,
		input logic [1:0]  err,
		input logic        pend
	);
		result_t r;
		r            = base;
		r.kind       = kind;
		r.value      = value;
		r.pid_valid  = has_pid;
		r.error_code = err;
		r.packet_end = pend;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/vpn_control_header_parser.sv =====
// ----------------------------------------------------------------------------
// vpn_control_header_parser
// Walks a control packet one byte per item and emits ack ids, a header
// record, payload bytes, or an error record.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  byte     | byte_valid / byte_stall    | data_byte, last
//  result   | result_valid/result_stall  | kind .. packet_end
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One byte is taken per cycle while the input does not stall. A byte is held
// in the input register, is parsed there, and its results go into an 8-entry
// result queue; the first one is visible the next cycle. The input stalls only
// while the queue holds more than four results (a byte can cause up to four).
// Reset clears the parse state and loads max_ack_count = 8 and
// ack_only_opcode = 5.
// ----------------------------------------------------------------------------
`default_nettype none

module vpn_control_header_parser #(
	parameter int SESSION_ID_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,

	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       kind,
	output logic [4:0]       opcode,
	output logic [2:0]       key_id,
	output logic [63:0]      peer_session,
	output logic [7:0]       ack_total,
	output logic [31:0]      value,
	output logic             pid_valid,
	output logic [1:0]       error_code,
	output logic             packet_end,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import vcp_pkg::*;

	localparam logic [3:0] SID_BYTES = 4'(SESSION_ID_BYTES);
	localparam int         PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int         CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// Configuration registers
	logic [7:0] max_ack_q;
	logic [4:0] ack_only_q;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parse state
	phase_t      phase_q, phase_d;
	logic [3:0]  bcnt_q, bcnt_d;
	logic [4:0]  op_q, op_d;
	logic [2:0]  key_q, key_d;
	logic [63:0] sess_q, sess_d;
	logic [7:0]  ann_q, ann_d;
	logic [7:0]  left_q, left_d;
	logic [31:0] wsh_q, wsh_d;

	// Result queue
	result_t          queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Per-byte results
	result_t    res [MAX_RESULTS];
	logic [2:0] res_n;
	result_t    base;

	logic        room;
	logic        proc;
	logic        pop;
	logic [3:0]  bcnt_inc;
	logic [31:0] wsh_new;
	logic [7:0]  left_dec;

	assign cfg_ready  = 1'b1;
	assign room       = count_q <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS);
	assign proc       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign pop        = result_valid && !result_stall;

	assign bcnt_inc = bcnt_q + 4'd1;
	assign wsh_new  = {wsh_q[23:0], byte_s1};
	assign left_dec = left_q - 8'd1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ack_q  <= 8'd8;
			ack_only_q <= 5'd5;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_ACK_COUNT:   max_ack_q  <= cfg_data;
				REG_ACK_ONLY_OPCODE: ack_only_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	// Next parse state
	always_comb begin
		phase_d = phase_q;
		bcnt_d  = bcnt_q;
		op_d    = op_q;
		key_d   = key_q;
		sess_d  = sess_q;
		ann_d   = ann_q;
		left_d  = left_q;
		wsh_d   = wsh_q;
		unique case (phase_q)
			PH_OP: begin
				op_d    = byte_s1[7:3];
				key_d   = byte_s1[2:0];
				sess_d  = '0;
				ann_d   = '0;
				left_d  = '0;
				wsh_d   = '0;
				bcnt_d  = '0;
				phase_d = last_s1 ? PH_OP : PH_SID;
			end
			PH_SID: begin
				sess_d = {sess_q[55:0], byte_s1};
				if (bcnt_inc >= SID_BYTES) begin
					bcnt_d  = '0;
					phase_d = last_s1 ? PH_OP : PH_CNT;
				end else begin
					bcnt_d  = bcnt_inc;
					phase_d = last_s1 ? PH_OP : PH_SID;
				end
			end
			PH_CNT: begin
				ann_d  = byte_s1;
				left_d = byte_s1;
				bcnt_d = '0;
				wsh_d  = '0;
				if (last_s1)
					phase_d = PH_OP;
				else if (byte_s1 > max_ack_q)
					phase_d = PH_DROP;
				else if (byte_s1 != 8'd0)
					phase_d = PH_ACK;
				else
					phase_d = PH_PID;
			end
			PH_ACK: begin
				if (bcnt_inc >= WORD_BYTES) begin
					bcnt_d  = '0;
					wsh_d   = '0;
					left_d  = left_dec;
					phase_d = last_s1 ? PH_OP : (left_dec == 8'd0 ? PH_ECHO : PH_ACK);
				end else begin
					bcnt_d  = bcnt_inc;
					wsh_d   = wsh_new;
					phase_d = last_s1 ? PH_OP : PH_ACK;
				end
			end
			PH_ECHO: begin
				if (bcnt_inc >= SID_BYTES) begin
					bcnt_d  = '0;
					wsh_d   = '0;
					phase_d = last_s1 ? PH_OP : PH_PID;
				end else begin
					bcnt_d  = bcnt_inc;
					phase_d = last_s1 ? PH_OP : PH_ECHO;
				end
			end
			PH_PID: begin
				if (op_q == ack_only_q) begin
					phase_d = last_s1 ? PH_OP : PH_PAY;
				end else begin
					wsh_d = wsh_new;
					if (bcnt_inc >= WORD_BYTES) begin
						bcnt_d  = '0;
						phase_d = last_s1 ? PH_OP : PH_PAY;
					end else if (last_s1) begin
						bcnt_d  = '0;
						phase_d = PH_OP;
					end else begin
						bcnt_d = bcnt_inc;
					end
				end
			end
			PH_PAY:  phase_d = last_s1 ? PH_OP : PH_PAY;
			PH_DROP: phase_d = last_s1 ? PH_OP : PH_DROP;
			default: phase_d = PH_OP;
		endcase
	end

	// Results of the current byte; packet-wide fields as updated by it
	always_comb begin
		base               = '0;
		base.opcode        = op_d;
		base.key_id        = key_d;
		base.peer_session  = sess_d;
		base.ack_total     = ann_d;
		for (int k = 0; k < MAX_RESULTS; k++)
			res[k] = base;
		res_n = 3'd0;
		unique case (phase_q)
			PH_OP: begin
				if (last_s1) begin
					res[0] = make_result(base, KIND_ERROR, '0, 1'b0, ERR_SESSION, 1'b1);
					res_n  = 3'd1;
				end
			end
			PH_SID, PH_ECHO: begin
				if (last_s1) begin
					if (bcnt_inc >= SID_BYTES)
						res[0] = make_result(base, KIND_HEADER, '0, 1'b0, ERR_NONE, 1'b1);
					else
						res[0] = make_result(base, KIND_ERROR, '0, 1'b0, ERR_SESSION, 1'b1);
					res_n = 3'd1;
				end
			end
			PH_CNT: begin
				if (byte_s1 > max_ack_q) begin
					res[0] = make_result(base, KIND_ERROR, '0, 1'b0, ERR_ACK_COUNT, 1'b1);
					res_n  = 3'd1;
				end else if (last_s1) begin
					if (byte_s1 != 8'd0)
						res[0] = make_result(base, KIND_ERROR, '0, 1'b0, ERR_ACK_LIST, 1'b1);
					else
						res[0] = make_result(base, KIND_HEADER, '0, 1'b0, ERR_NONE, 1'b1);
					res_n = 3'd1;
				end
			end
			PH_ACK: begin
				if (bcnt_inc >= WORD_BYTES) begin
					res[0] = make_result(base, KIND_ACK, wsh_new, 1'b0, ERR_NONE, 1'b0);
					res_n  = 3'd1;
					if (last_s1) begin
						// list complete but echoed id missing, or list cut short
						if (left_dec == 8'd0)
							res[1] = make_result(base, KIND_ERROR, '0, 1'b0, ERR_SESSION,
								1'b1);
						else
							res[1] = make_result(base, KIND_ERROR, '0, 1'b0, ERR_ACK_LIST,
								1'b1);
						res_n = 3'd2;
					end
				end else if (last_s1) begin
					res[0] = make_result(base, KIND_ERROR, '0, 1'b0, ERR_ACK_LIST, 1'b1);
					res_n  = 3'd1;
				end
			end
			PH_PID: begin
				if (op_q == ack_only_q) begin
					res[0] = make_result(base, KIND_HEADER, '0, 1'b0, ERR_NONE, 1'b0);
					res[1] = make_result(base, KIND_PAYLOAD, {24'd0, byte_s1}, 1'b0,
						ERR_NONE, last_s1);
					res_n  = 3'd2;
				end else if (bcnt_inc >= WORD_BYTES) begin
					res[0] = make_result(base, KIND_HEADER, wsh_new, 1'b1, ERR_NONE,
						last_s1);
					res_n  = 3'd1;
				end else if (last_s1) begin
					// short packet id: header, then the gathered bytes as payload
					res[0] = make_result(base, KIND_HEADER, '0, 1'b0, ERR_NONE, 1'b0);
					case (bcnt_inc[1:0])
						2'd1: begin
							res[1] = make_result(base, KIND_PAYLOAD, {24'd0, wsh_new[7:0]},
								1'b0, ERR_NONE, 1'b1);
							res_n  = 3'd2;
						end
						2'd2: begin
							res[1] = make_result(base, KIND_PAYLOAD, {24'd0, wsh_new[15:8]},
								1'b0, ERR_NONE, 1'b0);
							res[2] = make_result(base, KIND_PAYLOAD, {24'd0, wsh_new[7:0]},
								1'b0, ERR_NONE, 1'b1);
							res_n  = 3'd3;
						end
						default: begin
							res[1] = make_result(base, KIND_PAYLOAD,
								{24'd0, wsh_new[23:16]}, 1'b0, ERR_NONE, 1'b0);
							res[2] = make_result(base, KIND_PAYLOAD, {24'd0, wsh_new[15:8]},
								1'b0, ERR_NONE, 1'b0);
							res[3] = make_result(base, KIND_PAYLOAD, {24'd0, wsh_new[7:0]},
								1'b0, ERR_NONE, 1'b1);
							res_n  = 3'd4;
						end
					endcase
				end
			end
			PH_PAY: begin
				res[0] = make_result(base, KIND_PAYLOAD, {24'd0, byte_s1}, 1'b0, ERR_NONE,
					last_s1);
				res_n  = 3'd1;
			end
			PH_DROP: res_n = 3'd0;
			default: res_n = 3'd0;
		endcase
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OP;
			bcnt_q  <= '0;
			op_q    <= '0;
			key_q   <= '0;
			sess_q  <= '0;
			ann_q   <= '0;
			left_q  <= '0;
			wsh_q   <= '0;
		end else if (proc) begin
			phase_q <= phase_d;
			bcnt_q  <= bcnt_d;
			op_q    <= op_d;
			key_q   <= key_d;
			sess_q  <= sess_d;
			ann_q   <= ann_d;
			left_q  <= left_d;
			wsh_q   <= wsh_d;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (proc)
				wr_ptr_q <= wr_ptr_q + PTR_W'(res_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (proc ? CNT_W'(res_n) : CNT_W'(0))
				- (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// Result queue entries
	always_ff @(posedge clk) begin
		if (proc) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				if (3'(k) < res_n)
					queue_q[wr_ptr_q + PTR_W'(k)] <= res[k];
			end
		end
	end

	// Result port
	assign result_valid = count_q != '0;
	assign kind         = queue_q[rd_ptr_q].kind;
	assign opcode       = queue_q[rd_ptr_q].opcode;
	assign key_id       = queue_q[rd_ptr_q].key_id;
	assign peer_session = queue_q[rd_ptr_q].peer_session;
	assign ack_total    = queue_q[rd_ptr_q].ack_total;
	assign value        = queue_q[rd_ptr_q].value;
	assign pid_valid    = queue_q[rd_ptr_q].pid_valid;
	assign error_code   = queue_q[rd_ptr_q].error_code;
	assign packet_end   = queue_q[rd_ptr_q].packet_end;

endmodule

`default_nettype wire
